>>> rtl/srec_pkg.sv
// Shared constants, types and helpers for the S-record text encoder.
package srec_pkg;

    localparam int ADDR_W                   = 24;
    localparam int BYTE_W                   = 8;
    localparam int CHAR_W                   = 7;
    localparam int CFG_INDEX_W              = 2;
    localparam int DEFAULT_BYTES_PER_RECORD = 20;

    localparam logic [ADDR_W-1:0] RESET_ADDRESS = 24'h001000;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LOAD_ADDRESS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_ADDRESS = 2'd1;

    // Input commands
    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [BYTE_W-1:0] END_COUNT = 8'h04;
    localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'hFF;

    localparam logic [CHAR_W-1:0] CHAR_S     = 7'h53;
    localparam logic [CHAR_W-1:0] CHAR_TWO   = 7'h32;
    localparam logic [CHAR_W-1:0] CHAR_EIGHT = 7'h38;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 7'h0A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_HEXA  = 7'h37;  // 'A' - 10

    // Symbol selection codes, controller to datapath
    typedef logic [3:0] srec_sel_t;
    localparam srec_sel_t SEL_S        = 4'd0;
    localparam srec_sel_t SEL_TWO      = 4'd1;
    localparam srec_sel_t SEL_EIGHT    = 4'd2;
    localparam srec_sel_t SEL_CNT_DATA = 4'd3;
    localparam srec_sel_t SEL_CNT_END  = 4'd4;
    localparam srec_sel_t SEL_LA2      = 4'd5;
    localparam srec_sel_t SEL_LA1      = 4'd6;
    localparam srec_sel_t SEL_LA0      = 4'd7;
    localparam srec_sel_t SEL_EA2      = 4'd8;
    localparam srec_sel_t SEL_EA1      = 4'd9;
    localparam srec_sel_t SEL_EA0      = 4'd10;
    localparam srec_sel_t SEL_DATA     = 4'd11;
    localparam srec_sel_t SEL_CHK      = 4'd12;
    localparam srec_sel_t SEL_CR       = 4'd13;
    localparam srec_sel_t SEL_LF       = 4'd14;

    typedef struct packed {
        logic      emit;
        srec_sel_t sel;
        logic      nib_lo;
        logic      last;
        logic      sum_clear;
        logic      sum_add;
        logic      byte_load;
        logic      advance;
        logic      image_clear;
    } srec_cmd_t;

    typedef struct packed {
        logic pos_zero;
        logic rec_full;
        logic out_free;
    } srec_status_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
        logic [CHAR_W-1:0] c;
        if (v < 4'd10)
            c = CHAR_ZERO + {3'b000, v};
        else
            c = CHAR_HEXA + {3'b000, v};
        return c;
    endfunction

endpackage

>>> rtl/srec_in_if.sv
// Input channel: image bytes and finish commands.
interface srec_in_if
    import srec_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

>>> rtl/srec_out_if.sv
// Output channel: one ASCII character per transaction.
interface srec_out_if
    import srec_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ascii_char;
    logic              last_of_run;

    modport source (output valid, output ascii_char, output last_of_run, input ready);
    modport sink   (input valid, input ascii_char, input last_of_run, output ready);
endinterface

>>> rtl/srec_cfg_if.sv
// Configuration write channel.
interface srec_cfg_if
    import srec_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [ADDR_W-1:0]      reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

>>> rtl/srecord_text_encoder_core.sv
// Top level of the S-record text encoder: controller plus datapath.
//
// data_in carries image bytes (command 0) or a finish command (command 1).
// Each byte is turned into S2 record text on char_out, one ASCII character
// per transaction; last_of_run marks the final character of each input
// transaction. A finish pads an open record with FF bytes, then sends the
// S8 end record and returns the offset to zero for the next image.
// cfg writes load_address (index 0) and entry_address (index 1); it is
// always ready and other indexes are ignored.
// Sequence: the controller takes an input transaction while idle, then its
// sequencer issues one character per cycle while char_out is not stalled.
// A byte inside a record sends its data characters; the first byte of a
// record sends S2, count, address and data, the last data, checksum, CR, LF.
// A finish sends any padding record text, then the S8 end record.
// data_in is taken again only once the sequencer has placed the last
// character of the previous transaction in the output register, which
// holds its character while char_out stalls; the sequencer waits with it.
// Reset sets both addresses to 0x1000 and clears position, offset and sum.
module srecord_text_encoder_core
    import srec_pkg::*;
#(
    parameter int BYTES_PER_RECORD = DEFAULT_BYTES_PER_RECORD
)
(
    input  logic       clk,
    input  logic       rst_n,
    srec_in_if.sink    data_in,
    srec_out_if.source char_out,
    srec_cfg_if.sink   cfg
);

    srec_cmd_t    cmd;
    srec_status_t status;

    srec_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (data_in.valid),
        .in_command (data_in.command),
        .in_ready   (data_in.ready),
        .status     (status),
        .cmd        (cmd)
    );

    srec_datapath #(
        .BYTES_PER_RECORD (BYTES_PER_RECORD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .command   (data_in.command),
        .data_byte (data_in.data_byte),
        .cfg       (cfg),
        .char_out  (char_out)
    );

endmodule

>>> rtl/srec_datapath.sv
// Datapath: address and checksum registers, symbol selection, output register.
module srec_datapath
    import srec_pkg::*;
#(
    parameter int BYTES_PER_RECORD = DEFAULT_BYTES_PER_RECORD
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  srec_cmd_t         cmd,
    output srec_status_t      status,
    input  logic              command,
    input  logic [BYTE_W-1:0] data_byte,
    srec_cfg_if.sink          cfg,
    srec_out_if.source        char_out
);

    localparam int POS_W = $clog2(BYTES_PER_RECORD + 1);
    localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(BYTES_PER_RECORD - 1);
    localparam logic [BYTE_W-1:0] DATA_COUNT = BYTE_W'(BYTES_PER_RECORD + 4);

    logic [ADDR_W-1:0] load_addr_reg;
    logic [ADDR_W-1:0] entry_addr_reg;
    logic [ADDR_W-1:0] offset_reg;
    logic [ADDR_W-1:0] offset_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic              last_reg;
    logic              last_next;

    logic [ADDR_W-1:0] rec_addr;
    logic [BYTE_W-1:0] sel_byte;
    logic [3:0]        nibble;

    assign rec_addr = load_addr_reg + offset_reg;

    always_comb
    begin
        case (cmd.sel)
            SEL_CNT_DATA: sel_byte = DATA_COUNT;
            SEL_CNT_END:  sel_byte = END_COUNT;
            SEL_LA2:      sel_byte = rec_addr[23:16];
            SEL_LA1:      sel_byte = rec_addr[15:8];
            SEL_LA0:      sel_byte = rec_addr[7:0];
            SEL_EA2:      sel_byte = entry_addr_reg[23:16];
            SEL_EA1:      sel_byte = entry_addr_reg[15:8];
            SEL_EA0:      sel_byte = entry_addr_reg[7:0];
            SEL_DATA:     sel_byte = byte_reg;
            SEL_CHK:      sel_byte = ~sum_reg;
            default:      sel_byte = byte_reg;
        endcase
    end

    assign nibble = cmd.nib_lo ? sel_byte[3:0] : sel_byte[7:4];

    always_comb
    begin
        case (cmd.sel)
            SEL_S:     char_next = CHAR_S;
            SEL_TWO:   char_next = CHAR_TWO;
            SEL_EIGHT: char_next = CHAR_EIGHT;
            SEL_CR:    char_next = CHAR_CR;
            SEL_LF:    char_next = CHAR_LF;
            default:   char_next = hex_char(nibble);
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        last_next      = last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            last_next      = cmd.last;
        end
        else if (char_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        sum_next = sum_reg;
        if (cmd.sum_clear || cmd.image_clear)
            sum_next = '0;
        else if (cmd.sum_add)
            sum_next = sum_reg + sel_byte;

        pos_next    = pos_reg;
        offset_next = offset_reg;
        if (cmd.image_clear)
        begin
            pos_next    = '0;
            offset_next = '0;
        end
        else if (cmd.advance)
        begin
            pos_next    = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
            offset_next = offset_reg + 1'b1;
        end

        byte_next = byte_reg;
        if (cmd.byte_load)
            byte_next = (command == CMD_FINISH) ? PAD_BYTE : data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_addr_reg  <= RESET_ADDRESS;
            entry_addr_reg <= RESET_ADDRESS;
            offset_reg     <= '0;
            pos_reg        <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            if (cfg.valid)
            begin
                case (cfg.reg_index)
                    REG_LOAD_ADDRESS:  load_addr_reg  <= cfg.reg_data;
                    REG_ENTRY_ADDRESS: entry_addr_reg <= cfg.reg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (cmd.emit)
            char_reg <= char_next;
    end

    assign cfg.ready            = 1'b1;
    assign char_out.valid       = out_valid_reg;
    assign char_out.ascii_char  = char_reg;
    assign char_out.last_of_run = last_reg;

    assign status.pos_zero = (pos_reg == '0);
    assign status.rec_full = (pos_reg == POS_LAST);
    assign status.out_free = !out_valid_reg || char_out.ready;

endmodule

>>> rtl/srec_controller.sv
// Controller: sequences the characters of each record, one per cycle while the output is free.
module srec_controller
    import srec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_command,
    output logic         in_ready,
    input  srec_status_t status,
    output srec_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_S     = 4'd1;
    localparam logic [3:0] ST_TYPE  = 4'd2;
    localparam logic [3:0] ST_COUNT = 4'd3;
    localparam logic [3:0] ST_A2    = 4'd4;
    localparam logic [3:0] ST_A1    = 4'd5;
    localparam logic [3:0] ST_A0    = 4'd6;
    localparam logic [3:0] ST_DATA  = 4'd7;
    localparam logic [3:0] ST_CHK   = 4'd8;
    localparam logic [3:0] ST_CR    = 4'd9;
    localparam logic [3:0] ST_LF    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       nib_reg;
    logic       nib_next;
    logic       is_end_reg;      // current record is the S8 end record
    logic       is_end_next;
    logic       finishing_reg;   // a finish transaction is in progress
    logic       finishing_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        nib_next       = nib_reg;
        is_end_next    = is_end_reg;
        finishing_next = finishing_reg;
        cmd            = '0;
        cmd.sel        = SEL_S;
        cmd.nib_lo     = nib_reg;

        case (state_reg)
            ST_IDLE:
            begin
                nib_next = 1'b0;
                if (in_valid)
                begin
                    cmd.byte_load  = 1'b1;
                    finishing_next = in_command;
                    is_end_next    = (in_command == CMD_FINISH) && status.pos_zero;
                    state_next     = status.pos_zero ? ST_S : ST_DATA;
                end
            end
            ST_S:
            begin
                cmd.sel = SEL_S;
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.sum_clear = 1'b1;
                    state_next    = ST_TYPE;
                end
            end
            ST_TYPE:
            begin
                cmd.sel = is_end_reg ? SEL_EIGHT : SEL_TWO;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT, ST_A2, ST_A1, ST_A0, ST_DATA:
            begin
                case (state_reg)
                    ST_COUNT: cmd.sel = is_end_reg ? SEL_CNT_END : SEL_CNT_DATA;
                    ST_A2:    cmd.sel = is_end_reg ? SEL_EA2 : SEL_LA2;
                    ST_A1:    cmd.sel = is_end_reg ? SEL_EA1 : SEL_LA1;
                    ST_A0:    cmd.sel = is_end_reg ? SEL_EA0 : SEL_LA0;
                    default:  cmd.sel = SEL_DATA;
                endcase
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sum_add = !nib_reg;
                    nib_next    = !nib_reg;
                    if (nib_reg)
                    begin
                        case (state_reg)
                            ST_COUNT: state_next = ST_A2;
                            ST_A2:    state_next = ST_A1;
                            ST_A1:    state_next = ST_A0;
                            ST_A0:    state_next = is_end_reg ? ST_CHK : ST_DATA;
                            default:
                            begin
                                cmd.advance = 1'b1;
                                if (status.rec_full)
                                    state_next = ST_CHK;
                                else if (!finishing_reg)
                                begin
                                    cmd.last   = 1'b1;
                                    state_next = ST_IDLE;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_CHK:
            begin
                cmd.sel = SEL_CHK;
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    nib_next = !nib_reg;
                    if (nib_reg)
                        state_next = ST_CR;
                end
            end
            ST_CR:
            begin
                cmd.sel = SEL_CR;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_LF;
                end
            end
            ST_LF:
            begin
                cmd.sel = SEL_LF;
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (is_end_reg)
                    begin
                        cmd.last        = 1'b1;
                        cmd.image_clear = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else if (finishing_reg)
                    begin
                        is_end_next = 1'b1;
                        state_next  = ST_S;
                    end
                    else
                    begin
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nib_reg       <= 1'b0;
            is_end_reg    <= 1'b0;
            finishing_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nib_reg       <= nib_next;
            is_end_reg    <= is_end_next;
            finishing_reg <= finishing_next;
        end
    end

endmodule
